/* hdl/rps_pkg.sv */
// ----------------------------------------------------------------------------
// rps_pkg
// Shared constants, register indexes and types of the permutation shuffler.
// ----------------------------------------------------------------------------
`default_nettype none

package rps_pkg;

  // Default size of the slot table.
  localparam int DEF_MAX_ITEMS = 1024;

  // Field widths.
  localparam int WORD_W    = 31;
  localparam int VALUE_W   = 32;
  localparam int CFG_IDX_W = 1;

  // Depth of the small queues between the parts.
  localparam int QUEUE_DEPTH = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;

  // Round tags kept next to each slot entry. A tag equal to the current
  // round's tag marks the slot as written in this round.
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_NONE  = '0;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

  // Sequencer states of the back end.
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_WRITE
  } back_state_t;

endpackage

`default_nettype wire

/* hdl/rps_fifo.sv */
// ----------------------------------------------------------------------------
// rps_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = rps_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import rps_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_wr;
  logic             do_rd;

  assign full    = (fill == CW'(DEPTH));
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = store[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CW'(1);
      end
    end
  end

  // Item storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* hdl/rps_front.sv */
// ----------------------------------------------------------------------------
// rps_front
// Holds the range registers, derives the element count and passes each
// accepted item on to the back end unless the range is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_front #(
  parameter int MAX_ITEMS = rps_pkg::DEF_MAX_ITEMS,
  localparam int CNT_W    = $clog2(MAX_ITEMS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [rps_pkg::WORD_W-1:0]    random_word,
  input  logic                          cfg_write,
  input  logic [rps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rps_pkg::VALUE_W-1:0]   cfg_data,
  output logic                          q_push,
  output logic [rps_pkg::WORD_W-1:0]    q_word,
  input  logic                          q_full,
  output logic [CNT_W-1:0]              count,
  output logic [rps_pkg::VALUE_W-1:0]   range_low,
  output logic                          restart
);
  import rps_pkg::*;

  localparam logic signed [VALUE_W:0] SPAN_CAP = (VALUE_W + 1)'(MAX_ITEMS - 1);

  logic [VALUE_W-1:0]        range_high;
  logic signed [VALUE_W:0]   span;
  logic                      range_empty;

  // Configuration registers; any write starts a new round.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_low  <= '0;
      range_high <= '1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RANGE_LOW:  range_low  <= cfg_data;
        REG_RANGE_HIGH: range_high <= cfg_data;
      endcase
    end
  end

  assign restart = cfg_write;

  // Span of the range as a signed difference; negative means empty.
  always_comb begin
    span = $signed({range_high[VALUE_W-1], range_high})
         - $signed({range_low[VALUE_W-1], range_low});
    range_empty = span[VALUE_W];
    if (!range_empty && (span >= SPAN_CAP)) begin
      count = CNT_W'(MAX_ITEMS);
    end else begin
      count = span[CNT_W-1:0] + CNT_W'(1);
    end
  end

  // Items against an empty range are taken and dropped.
  assign full   = q_full;
  assign q_push = push && !q_full && !range_empty;
  assign q_word = random_word;

endmodule

`default_nettype wire

/* hdl/rps_mod_div.sv */
// ----------------------------------------------------------------------------
// rps_mod_div
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_mod_div #(
  parameter int DW = rps_pkg::WORD_W,
  parameter int VW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [VW-1:0] remainder
);
  import rps_pkg::*;

  localparam int SW = $clog2(DW + 1);

  logic [DW-1:0] shreg;
  logic [VW-1:0] dvs;
  logic [SW-1:0] steps;
  logic          busy;
  logic [VW:0]   trial;
  logic [VW:0]   diff;

  // One step: bring in the next bit and subtract when it fits.
  assign trial = {remainder, shreg[DW-1]};
  assign diff  = trial - {1'b0, dvs};

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= SW'(DW);
      end else if (busy) begin
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg     <= dividend;
      dvs       <= divisor;
      remainder <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      if (trial >= {1'b0, dvs}) begin
        remainder <= diff[VW-1:0];
      end else begin
        remainder <= trial[VW-1:0];
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/rps_back.sv */
// ----------------------------------------------------------------------------
// rps_back
// Swap sequencer: takes one random word at a time, picks the swap slot,
// does the read-modify-write of the slot table and queues the result.
// ----------------------------------------------------------------------------
`default_nettype none

module rps_back #(
  parameter int MAX_ITEMS = rps_pkg::DEF_MAX_ITEMS,
  localparam int CNT_W    = $clog2(MAX_ITEMS + 1),
  localparam int IDX_W    = $clog2(MAX_ITEMS)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_empty,
  output logic                        q_pop,
  input  logic [rps_pkg::WORD_W-1:0]  q_word,
  input  logic [CNT_W-1:0]            count,
  input  logic [rps_pkg::VALUE_W-1:0] range_low,
  input  logic                        restart,
  input  logic                        out_full,
  output logic                        out_push,
  output logic [rps_pkg::VALUE_W-1:0] out_value,
  output logic                        out_last
);
  import rps_pkg::*;

  localparam int ENT_W = EPOCH_W + IDX_W;

  back_state_t       state;
  back_state_t       state_next;
  logic [IDX_W-1:0]  position;
  logic [IDX_W-1:0]  position_next;
  logic [EPOCH_W-1:0] epoch;
  logic [EPOCH_W-1:0] epoch_next;
  logic [IDX_W-1:0]  clr_addr;
  logic [IDX_W-1:0]  clr_addr_next;
  logic [IDX_W-1:0]  pick_addr;
  logic [IDX_W-1:0]  pick_addr_next;

  logic [ENT_W-1:0]  slot_mem [MAX_ITEMS];
  logic [ENT_W-1:0]  rd_pick;
  logic [ENT_W-1:0]  rd_here;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ENT_W-1:0]  mem_wdata;

  logic              div_start;
  logic              div_done;
  logic [CNT_W-1:0]  div_rem;

  logic [IDX_W-1:0]  pick;
  logic [IDX_W-1:0]  here;
  logic              is_last;
  logic              wrap;

  // Remainder of the random word by the number of slots still open.
  rps_mod_div #(
    .DW (WORD_W),
    .VW (CNT_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (q_word),
    .divisor   (count - CNT_W'(position)),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Slot table: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    if (state == ST_READ) begin
      rd_pick <= slot_mem[pick_addr];
      rd_here <= slot_mem[position];
    end
  end

  // A slot not written in this round reads as its own offset.
  assign pick    = (rd_pick[ENT_W-1 -: EPOCH_W] == epoch) ? rd_pick[IDX_W-1:0] : pick_addr;
  assign here    = (rd_here[ENT_W-1 -: EPOCH_W] == epoch) ? rd_here[IDX_W-1:0] : position;
  assign is_last = ((CNT_W'(position) + CNT_W'(1)) == count);
  assign wrap    = (epoch == EPOCH_LAST);

  assign out_value = range_low + VALUE_W'(pick);
  assign out_last  = is_last;

  // State register and sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      position  <= '0;
      epoch     <= EPOCH_FIRST;
      clr_addr  <= '0;
      pick_addr <= '0;
    end else begin
      state     <= state_next;
      position  <= position_next;
      epoch     <= epoch_next;
      clr_addr  <= clr_addr_next;
      pick_addr <= pick_addr_next;
    end
  end

  // Next state and outputs.
  always_comb begin
    state_next     = state;
    position_next  = position;
    epoch_next     = epoch;
    clr_addr_next  = clr_addr;
    pick_addr_next = pick_addr;
    q_pop          = 1'b0;
    div_start      = 1'b0;
    out_push       = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = pick_addr;
    mem_wdata      = {epoch, here};

    unique case (state)
      // Tag sweep after reset and whenever the round tag wraps.
      ST_CLEAR: begin
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        mem_wdata     = {EPOCH_NONE, IDX_W'(0)};
        clr_addr_next = clr_addr + IDX_W'(1);
        if (clr_addr == IDX_W'(MAX_ITEMS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          pick_addr_next = position + div_rem[IDX_W-1:0];
          state_next     = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_WRITE;
      end
      // Swap the current slot into the picked one and emit the pick.
      ST_WRITE: begin
        if (!out_full) begin
          mem_we     = 1'b1;
          out_push   = 1'b1;
          state_next = ST_IDLE;
          if (is_last) begin
            position_next = '0;
            if (wrap) begin
              epoch_next    = EPOCH_FIRST;
              clr_addr_next = '0;
              state_next    = ST_CLEAR;
            end else begin
              epoch_next = epoch + EPOCH_W'(1);
            end
          end else begin
            position_next = position + IDX_W'(1);
          end
        end
      end
    endcase

    // A register write starts a new round.
    if (restart) begin
      position_next = '0;
      if (wrap) begin
        epoch_next    = EPOCH_FIRST;
        clr_addr_next = '0;
        state_next    = ST_CLEAR;
      end else begin
        epoch_next = epoch + EPOCH_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/random_permutation_shuffle.sv */
// ----------------------------------------------------------------------------
// random_permutation_shuffle
// Fisher-Yates shuffle of range_low..range_high, one element per random word.
// ----------------------------------------------------------------------------
// Each pushed random word yields the next element of a random permutation of
// range_low..range_high (clamped to MAX_ITEMS elements); last marks the final
// element of a round, and the next word starts a new round. Words pushed
// while the range is empty are taken and give no result. An item passes
// through a dequeue, the bit-serial remainder unit that reduces the word by
// the number of open slots (its bit steps, then the hand-over of the
// remainder), then one table read and one table write. After reset, and after
// every 255 rounds when the round tag of the slot table wraps, the block
// sweeps all MAX_ITEMS table entries and takes no item meanwhile; full
// rises once the two-entry input queue is filled.
// Any register write starts a new round.
// ----------------------------------------------------------------------------
`default_nettype none

module random_permutation_shuffle #(
  parameter int MAX_ITEMS = rps_pkg::DEF_MAX_ITEMS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [rps_pkg::WORD_W-1:0]    random_word,
  output logic                          empty,
  input  logic                          pop,
  output logic [rps_pkg::VALUE_W-1:0]   value,
  output logic                          last,
  input  logic                          cfg_write,
  input  logic [rps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rps_pkg::VALUE_W-1:0]   cfg_data
);
  import rps_pkg::*;

  localparam int CNT_W = $clog2(MAX_ITEMS + 1);

  logic               q_push;
  logic [WORD_W-1:0]  q_wr_word;
  logic               q_full;
  logic               q_pop;
  logic [WORD_W-1:0]  q_rd_word;
  logic               q_empty;
  logic [CNT_W-1:0]   count;
  logic [VALUE_W-1:0] range_low;
  logic               restart;
  logic               out_push;
  logic               out_full;
  logic [VALUE_W-1:0] out_value;
  logic               out_last;

  // Register file and item intake.
  rps_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .random_word (random_word),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .q_push      (q_push),
    .q_word      (q_wr_word),
    .q_full      (q_full),
    .count       (count),
    .range_low   (range_low),
    .restart     (restart)
  );

  // Queue of random words between intake and swap sequencer.
  rps_fifo #(
    .WIDTH (WORD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_word_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wr_word),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_word),
    .empty   (q_empty)
  );

  // Swap sequencer with the slot table.
  rps_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .q_word    (q_rd_word),
    .count     (count),
    .range_low (range_low),
    .restart   (restart),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_value (out_value),
    .out_last  (out_last)
  );

  // Result queue.
  rps_fifo #(
    .WIDTH (VALUE_W + 1),
    .DEPTH (QUEUE_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (out_push),
    .wr_data ({out_last, out_value}),
    .full    (out_full),
    .rd_en   (pop),
    .rd_data ({last, value}),
    .empty   (empty)
  );

endmodule

`default_nettype wire
